// ----- rtl/lcwc_pkg.sv -----
// Shared types and constants for the load cell weight conditioner.
// Used by the cell modules and by the top level; depends on nothing.
package lcwc_pkg;

	// Configuration register indexes.
	localparam int CFG_IW = 3;
	localparam logic [CFG_IW-1:0] REG_ZERO_OFFSET = 3'd0;
	localparam logic [CFG_IW-1:0] REG_COUNT_GAIN = 3'd1;
	localparam logic [CFG_IW-1:0] REG_ZERO_BAND = 3'd2;
	localparam logic [CFG_IW-1:0] REG_SPIKE_LIMIT = 3'd3;
	localparam logic [CFG_IW-1:0] REG_OUTLIER_LIMIT = 3'd4;
	localparam logic [CFG_IW-1:0] REG_FAULT_LIMIT = 3'd5;
	localparam logic [CFG_IW-1:0] REG_STABLE_LIMIT = 3'd6;

	localparam int CFG_DW = 48;
	localparam int WEIGHT_W = 32;
	localparam int VAR_W = 48;
	localparam int ACC_W = 64;

	// Control of the median cells.
	typedef struct packed {
		logic shift;
		logic load;
		logic step;
	} med_ctl_t;

	// Control of the averaging cells.
	typedef struct packed {
		logic shift;
		logic rotate;
	} avg_ctl_t;

endpackage

// ----- rtl/load_cell_weight_conditioner_unit.sv -----
// Load cell weight conditioner: top level with control sequencer and cell chains.
// Depends on lcwc_pkg, lcwc_med_cell, lcwc_avg_cell and lcwc_div.
//
// Usage:
// Input channel (in_valid/in_ready) carries converter_ready and raw_sample.
// A transfer with converter_ready low yields one result holding the last weight,
// with signal_good low and no state change; it waits for a free output register.
// A ready sample is scaled, spike-checked, ranked in the median chain, checked
// against the median, shifted into the averaging chain, then averaged and its
// variance taken. The time this takes is set by the two 64-step passes of the
// shared divider and by the rotations of the median and averaging chains, one
// cell per cycle. While the averaging window holds one entry the second divider
// pass is skipped.
// One item is worked on at a time; in_ready is high only when the sequencer idles.
// The result sits in an output register (out_valid/out_ready); the next item is
// taken while it waits, and that item's result is held back until it is taken.
// Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are always
// taken; indexes beyond the register list are ignored.
// Reset clears the windows' fill counts, the last weight and the registers to
// their defaults; no clearing pass is needed.
module load_cell_weight_conditioner_unit import lcwc_pkg::*; #(
	parameter int MEDIAN_DEPTH = 5,
	parameter int AVERAGE_DEPTH = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_IW-1:0]          cfg_index,
	input  logic [CFG_DW-1:0]          cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       converter_ready,
	input  logic signed [23:0]         raw_sample,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [23:0]         raw_echo,
	output logic signed [WEIGHT_W-1:0] median_weight,
	output logic signed [WEIGHT_W-1:0] filtered_weight,
	output logic [VAR_W-1:0]           window_variance,
	output logic                       signal_good,
	output logic                       stable,
	output logic                       sample_replaced
);

	localparam int MIW = (MEDIAN_DEPTH > 1) ? $clog2(MEDIAN_DEPTH) : 1;
	localparam int MRW = $clog2(MEDIAN_DEPTH + 1);
	localparam int ANW = $clog2(AVERAGE_DEPTH + 1);
	localparam int SW = WEIGHT_W + 1 + $clog2(AVERAGE_DEPTH + 1);
	localparam int KMAX = (AVERAGE_DEPTH + 1 > MEDIAN_DEPTH) ? AVERAGE_DEPTH + 1 : MEDIAN_DEPTH;
	localparam int KW = $clog2(KMAX + 1);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_MUL = 4'd1;
	localparam logic [3:0] S_W = 4'd2;
	localparam logic [3:0] S_LOAD = 4'd3;
	localparam logic [3:0] S_RANK = 4'd4;
	localparam logic [3:0] S_MED = 4'd5;
	localparam logic [3:0] S_OUT = 4'd6;
	localparam logic [3:0] S_SUM = 4'd7;
	localparam logic [3:0] S_D1S = 4'd8;
	localparam logic [3:0] S_D1W = 4'd9;
	localparam logic [3:0] S_VAR = 4'd10;
	localparam logic [3:0] S_D2S = 4'd11;
	localparam logic [3:0] S_D2W = 4'd12;
	localparam logic [3:0] S_FIN = 4'd13;

	// Configuration registers.
	logic signed [23:0] zero_offset_q;
	logic signed [31:0] count_gain_q;
	logic [30:0]        zero_band_q;
	logic [30:0]        spike_limit_q;
	logic [30:0]        outlier_limit_q;
	logic [VAR_W-1:0]   fault_limit_q;
	logic [VAR_W-1:0]   stable_limit_q;

	// Sequencer and working state.
	logic [3:0]                 state_q;
	logic [KW-1:0]              k_q;
	logic signed [23:0]         raw_q;
	logic signed [56:0]         prod_s1;
	logic signed [WEIGHT_W-1:0] w_q;
	logic signed [WEIGHT_W-1:0] med_q;
	logic signed [WEIGHT_W-1:0] last_weight_q;
	logic signed [WEIGHT_W-1:0] mean_q;
	logic signed [SW-1:0]       sum_q;
	logic [ACC_W-1:0]           acc_q;
	logic [MRW-1:0]             med_n_q;
	logic [ANW-1:0]             avg_n_q;
	logic                       rej_q;
	logic [32:0]                d_s1;
	logic                       v_s1;
	logic [ACC_W-1:0]           sq_s2;
	logic                       v_s2;

	// Result and output registers.
	logic signed [23:0]         res_raw_q;
	logic signed [WEIGHT_W-1:0] res_med_q;
	logic signed [WEIGHT_W-1:0] res_filt_q;
	logic [VAR_W-1:0]           res_var_q;
	logic                       res_ok_q;
	logic                       res_stable_q;
	logic                       res_rej_q;
	logic                       out_valid_q;
	logic signed [23:0]         raw_echo_q;
	logic signed [WEIGHT_W-1:0] median_weight_q;
	logic signed [WEIGHT_W-1:0] filtered_weight_q;
	logic [VAR_W-1:0]           window_variance_q;
	logic                       signal_good_q;
	logic                       stable_q;
	logic                       sample_replaced_q;

	// Chain signals.
	med_ctl_t                   mctl;
	avg_ctl_t                   actl;
	logic signed [WEIGHT_W-1:0] mval [MEDIAN_DEPTH];
	logic signed [WEIGHT_W-1:0] mpval [MEDIAN_DEPTH];
	logic [MIW-1:0]             mpidx [MEDIAN_DEPTH];
	logic [MRW-1:0]             mrank [MEDIAN_DEPTH];
	logic signed [WEIGHT_W-1:0] aval [AVERAGE_DEPTH];
	logic signed [WEIGHT_W-1:0] tap;
	logic                       tap_ok;

	// Divider.
	logic              div_start;
	logic [ACC_W-1:0]  div_dvd;
	logic              div_done;
	logic [ACC_W-1:0]  div_quot;

	// Combinational values.
	logic signed [40:0]         shifted;
	logic signed [WEIGHT_W-1:0] w_sat;
	logic [WEIGHT_W-1:0]        w_mag;
	logic signed [WEIGHT_W-1:0] w_band;
	logic signed [32:0]         jump;
	logic [32:0]                jump_mag;
	logic                       spike;
	logic signed [WEIGHT_W-1:0] w_new;
	logic [MRW-1:0]             rank_lo;
	logic [MRW-1:0]             rank_hi;
	logic [WEIGHT_W-1:0]        sel_lo;
	logic [WEIGHT_W-1:0]        sel_hi;
	logic signed [32:0]         mid_sum;
	logic signed [32:0]         med_gap;
	logic [32:0]                med_gap_mag;
	logic                       far;
	logic signed [WEIGHT_W-1:0] w_avg;
	logic [SW-1:0]              sum_mag;
	logic [31:0]                q32;
	logic signed [32:0]         mean_x;
	logic signed [WEIGHT_W-1:0] mean_new;
	logic signed [32:0]         dev;
	logic [ACC_W:0]             acc_sum;
	logic [VAR_W-1:0]           var_nxt;
	logic                       out_free;

	assign cfg_ready = 1'b1;
	assign in_ready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || out_ready;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_offset_q <= '0;
			count_gain_q <= 32'sd65536;
			zero_band_q <= 31'd16;
			spike_limit_q <= 31'd16000;
			outlier_limit_q <= 31'd1600;
			fault_limit_q <= 48'd25600000;
			stable_limit_q <= 48'd256;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ZERO_OFFSET: zero_offset_q <= cfg_data[23:0];
				REG_COUNT_GAIN: count_gain_q <= cfg_data[31:0];
				REG_ZERO_BAND: zero_band_q <= cfg_data[30:0];
				REG_SPIKE_LIMIT: spike_limit_q <= cfg_data[30:0];
				REG_OUTLIER_LIMIT: outlier_limit_q <= cfg_data[30:0];
				REG_FAULT_LIMIT: fault_limit_q <= cfg_data;
				REG_STABLE_LIMIT: stable_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Scaling, saturation, zero band and spike check.
	always_comb begin
		shifted = 41'(prod_s1 >>> 16);
		if (shifted > 41'sd2147483647) begin
			w_sat = 32'sh7FFFFFFF;
		end else if (shifted < -41'sd2147483648) begin
			w_sat = 32'sh80000000;
		end else begin
			w_sat = shifted[31:0];
		end
		w_mag = w_sat[31] ? 32'(-w_sat) : w_sat;
		w_band = (w_mag < {1'b0, zero_band_q}) ? '0 : w_sat;
		jump = 33'(w_band) - 33'(last_weight_q);
		jump_mag = jump[32] ? 33'(-jump) : 33'(jump);
		spike = jump_mag > {2'b0, spike_limit_q};
		w_new = spike ? last_weight_q : w_band;
	end

	// Median pick from the ranks: floor mean of the two middle entries.
	always_comb begin
		rank_lo = (med_n_q - MRW'(1)) >> 1;
		rank_hi = med_n_q >> 1;
		sel_lo = '0;
		sel_hi = '0;
		for (int i = 0; i < MEDIAN_DEPTH; i++) begin
			if ((MRW'(i) < med_n_q) && (mrank[i] == rank_lo)) begin
				sel_lo = sel_lo | mval[i];
			end
			if ((MRW'(i) < med_n_q) && (mrank[i] == rank_hi)) begin
				sel_hi = sel_hi | mval[i];
			end
		end
		mid_sum = 33'(signed'(sel_lo)) + 33'(signed'(sel_hi));
	end

	// Outlier check against the median.
	always_comb begin
		med_gap = 33'(w_q) - 33'(med_q);
		med_gap_mag = med_gap[32] ? 33'(-med_gap) : 33'(med_gap);
		far = med_gap_mag > {2'b0, outlier_limit_q};
		w_avg = far ? med_q : w_q;
	end

	// Mean from the divider, truncated toward zero, then zero band.
	always_comb begin
		sum_mag = sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);
		q32 = div_quot[31:0];
		mean_x = sum_q[SW-1] ? -$signed({1'b0, q32}) : $signed({1'b0, q32});
		mean_new = (q32 < {1'b0, zero_band_q}) ? '0 : mean_x[31:0];
	end

	// Variance terms.
	assign tap = aval[AVERAGE_DEPTH-1];
	assign tap_ok = (int'(k_q) + int'(avg_n_q)) >= AVERAGE_DEPTH;
	assign dev = 33'(tap) - 33'(mean_q);
	assign acc_sum = {1'b0, acc_q} + {1'b0, sq_s2};
	assign var_nxt = (state_q == S_D2S) ? '0 :
		((div_quot > ACC_W'({VAR_W{1'b1}})) ? {VAR_W{1'b1}} : div_quot[VAR_W-1:0]);

	// Divider hookup.
	assign div_start = (state_q == S_D1S) || ((state_q == S_D2S) && (avg_n_q > ANW'(1)));
	assign div_dvd = (state_q == S_D1S) ? ACC_W'(sum_mag) : acc_q;

	// Chain control.
	always_comb begin
		mctl.shift = (state_q == S_W);
		mctl.load = (state_q == S_LOAD);
		mctl.step = (state_q == S_RANK);
		actl.shift = (state_q == S_OUT);
		actl.rotate = (state_q == S_SUM) || ((state_q == S_VAR) && (k_q < KW'(AVERAGE_DEPTH)));
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q <= '0;
			med_n_q <= '0;
			avg_n_q <= '0;
			last_weight_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= converter_ready ? S_MUL : S_FIN;
					end
				end
				S_MUL: state_q <= S_W;
				S_W: begin
					if (med_n_q != MRW'(MEDIAN_DEPTH)) begin
						med_n_q <= med_n_q + MRW'(1);
					end
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					k_q <= '0;
					state_q <= S_RANK;
				end
				S_RANK: begin
					k_q <= k_q + KW'(1);
					if (k_q == KW'(MEDIAN_DEPTH - 1)) begin
						state_q <= S_MED;
					end
				end
				S_MED: state_q <= S_OUT;
				S_OUT: begin
					if (avg_n_q != ANW'(AVERAGE_DEPTH)) begin
						avg_n_q <= avg_n_q + ANW'(1);
					end
					k_q <= '0;
					state_q <= S_SUM;
				end
				S_SUM: begin
					k_q <= k_q + KW'(1);
					if (k_q == KW'(AVERAGE_DEPTH - 1)) begin
						state_q <= S_D1S;
					end
				end
				S_D1S: state_q <= S_D1W;
				S_D1W: begin
					if (div_done) begin
						last_weight_q <= mean_new;
						k_q <= '0;
						state_q <= S_VAR;
					end
				end
				S_VAR: begin
					v_s1 <= (k_q < KW'(AVERAGE_DEPTH)) && tap_ok;
					v_s2 <= v_s1;
					k_q <= k_q + KW'(1);
					if (k_q == KW'(AVERAGE_DEPTH + 1)) begin
						state_q <= S_D2S;
					end
				end
				S_D2S: state_q <= (avg_n_q > ANW'(1)) ? S_D2W : S_FIN;
				S_D2W: begin
					if (div_done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && in_valid) begin
			raw_q <= raw_sample;
			if (!converter_ready) begin
				res_raw_q <= '0;
				res_med_q <= last_weight_q;
				res_filt_q <= last_weight_q;
				res_var_q <= '0;
				res_ok_q <= 1'b0;
				res_stable_q <= 1'b0;
				res_rej_q <= 1'b0;
			end
		end
		if (state_q == S_MUL) begin
			prod_s1 <= 57'(25'(raw_q) - 25'(zero_offset_q)) * 57'(count_gain_q);
		end
		if (state_q == S_W) begin
			w_q <= w_new;
			rej_q <= spike;
		end
		if (state_q == S_MED) begin
			med_q <= mid_sum[32:1];
		end
		if (state_q == S_OUT) begin
			rej_q <= rej_q || far;
			sum_q <= '0;
		end
		if (state_q == S_SUM) begin
			if (tap_ok) begin
				sum_q <= sum_q + SW'(tap);
			end
		end
		if ((state_q == S_D1W) && div_done) begin
			mean_q <= mean_new;
			acc_q <= '0;
		end
		if (state_q == S_VAR) begin
			d_s1 <= dev[32] ? 33'(-dev) : 33'(dev);
			sq_s2 <= ACC_W'(66'(d_s1) * 66'(d_s1));
			if (v_s2) begin
				acc_q <= acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
			end
		end
		if (((state_q == S_D2S) && (avg_n_q <= ANW'(1))) || ((state_q == S_D2W) && div_done)) begin
			res_raw_q <= raw_q;
			res_med_q <= med_q;
			res_filt_q <= last_weight_q;
			res_var_q <= var_nxt;
			res_ok_q <= var_nxt < fault_limit_q;
			res_stable_q <= var_nxt <= stable_limit_q;
			res_rej_q <= rej_q;
		end
		if ((state_q == S_FIN) && out_free) begin
			raw_echo_q <= res_raw_q;
			median_weight_q <= res_med_q;
			filtered_weight_q <= res_filt_q;
			window_variance_q <= res_var_q;
			signal_good_q <= res_ok_q;
			stable_q <= res_stable_q;
			sample_replaced_q <= res_rej_q;
		end
	end

	// Median chain.
	for (genvar i = 0; i < MEDIAN_DEPTH; i++) begin : g_med
		localparam int P = (i == 0) ? MEDIAN_DEPTH - 1 : i - 1;
		lcwc_med_cell #(
			.CELL_IDX(i),
			.IW(MIW),
			.RW(MRW)
		) u_cell (
			.clk(clk),
			.ctl(mctl),
			.fill(med_n_q),
			.chain_val((i == 0) ? w_new : mval[P]),
			.nb_probe_val(mpval[P]),
			.nb_probe_idx(mpidx[P]),
			.val(mval[i]),
			.probe_val(mpval[i]),
			.probe_idx(mpidx[i]),
			.rank(mrank[i])
		);
	end

	// Averaging chain.
	for (genvar i = 0; i < AVERAGE_DEPTH; i++) begin : g_avg
		localparam int P = (i == 0) ? AVERAGE_DEPTH - 1 : i - 1;
		lcwc_avg_cell u_cell (
			.clk(clk),
			.ctl(actl),
			.chain_val(((i == 0) && actl.shift) ? w_avg : aval[P]),
			.val(aval[i])
		);
	end

	lcwc_div #(
		.DW(ACC_W),
		.NW(ANW)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_dvd),
		.divisor(avg_n_q),
		.done(div_done),
		.quotient(div_quot)
	);

	assign out_valid = out_valid_q;
	assign raw_echo = raw_echo_q;
	assign median_weight = median_weight_q;
	assign filtered_weight = filtered_weight_q;
	assign window_variance = window_variance_q;
	assign signal_good = signal_good_q;
	assign stable = stable_q;
	assign sample_replaced = sample_replaced_q;

`ifndef NO_ASSERTIONS
	// Window fill counts never pass their depths.
	a_med_fill: assert property (@(posedge clk) disable iff (!arst_n)
		med_n_q <= MRW'(MEDIAN_DEPTH))
		else $error("median fill count beyond depth");
	a_avg_fill: assert property (@(posedge clk) disable iff (!arst_n)
		avg_n_q <= ANW'(AVERAGE_DEPTH))
		else $error("averaging fill count beyond depth");
	// An accepted item always takes the sequencer out of idle.
	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q != S_IDLE)
		else $error("accepted item left sequencer idle");
	// The divider only finishes while the sequencer waits for it.
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_D1W) || (state_q == S_D2W))
		else $error("divider finished outside a wait state");
`endif

endmodule

// ----- rtl/lcwc_med_cell.sv -----
// One cell of the median window: a stored weight, a circulating probe and a rank count.
// Depends on lcwc_pkg.
module lcwc_med_cell import lcwc_pkg::*; #(
	parameter int CELL_IDX = 0,
	parameter int IW = 3,
	parameter int RW = 3
) (
	input  logic                       clk,
	input  med_ctl_t                   ctl,
	input  logic [RW-1:0]              fill,
	input  logic signed [WEIGHT_W-1:0] chain_val,
	input  logic signed [WEIGHT_W-1:0] nb_probe_val,
	input  logic [IW-1:0]              nb_probe_idx,
	output logic signed [WEIGHT_W-1:0] val,
	output logic signed [WEIGHT_W-1:0] probe_val,
	output logic [IW-1:0]              probe_idx,
	output logic [RW-1:0]              rank
);

	localparam logic [IW-1:0] MY_IDX = IW'(CELL_IDX);

	logic signed [WEIGHT_W-1:0] val_q;
	logic signed [WEIGHT_W-1:0] probe_val_q;
	logic [IW-1:0]              probe_idx_q;
	logic [RW-1:0]              rank_q;
	logic                       below;

	// The probe counts when it is a filled entry that sorts ahead of this one.
	assign below = (RW'(probe_idx_q) < fill) &&
		((probe_val_q < val_q) || ((probe_val_q == val_q) && (probe_idx_q < MY_IDX)));

	// Stored weight moves one cell down the window on each new sample.
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			val_q <= chain_val;
		end
	end

	// Probe load, then one probe per cycle from the neighbor.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			probe_val_q <= val_q;
			probe_idx_q <= MY_IDX;
			rank_q <= '0;
		end else if (ctl.step) begin
			probe_val_q <= nb_probe_val;
			probe_idx_q <= nb_probe_idx;
			if (below) begin
				rank_q <= rank_q + RW'(1);
			end
		end
	end

	assign val = val_q;
	assign probe_val = probe_val_q;
	assign probe_idx = probe_idx_q;
	assign rank = rank_q;

endmodule

// ----- rtl/lcwc_avg_cell.sv -----
// One cell of the averaging window: a stored weight that shifts in or rotates around.
// Depends on lcwc_pkg.
module lcwc_avg_cell import lcwc_pkg::*; (
	input  logic                       clk,
	input  avg_ctl_t                   ctl,
	input  logic signed [WEIGHT_W-1:0] chain_val,
	output logic signed [WEIGHT_W-1:0] val
);

	logic signed [WEIGHT_W-1:0] val_q;

	// Take the neighbor's value on a new sample or on a rotation step.
	always_ff @(posedge clk) begin
		if (ctl.shift || ctl.rotate) begin
			val_q <= chain_val;
		end
	end

	assign val = val_q;

endmodule

// ----- rtl/lcwc_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// Shared by the mean and the variance; depends on nothing.
module lcwc_div #(
	parameter int DW = 64,
	parameter int NW = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [NW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);

	localparam int CW = $clog2(DW + 1);

	logic [NW-1:0] rem_q;
	logic [DW-1:0] dvd_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;
	logic [NW:0]   trial;
	logic          fits;

	assign trial = {rem_q, dvd_q[DW-1]};
	assign fits = trial >= {1'b0, divisor};

	// Sequencing of the bit steps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(DW - 1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
		end else if (run_q) begin
			rem_q <= fits ? NW'(trial - {1'b0, divisor}) : trial[NW-1:0];
			dvd_q <= {dvd_q[DW-2:0], fits};
		end
	end

	assign done = done_q;
	assign quotient = dvd_q;

endmodule

// ----- tb/weight_conditioner_check.sv -----
`timescale 1ns / 100ps
// Watches the configuration, sample and result channels of the weight conditioner,
// predicts every result from its own copy of the filter state and compares it.
// Depends on lcwc_pkg for the register indexes and widths.
module weight_conditioner_check import lcwc_pkg::*; #(
	parameter int MEDIAN_DEPTH = 5,
	parameter int AVERAGE_DEPTH = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  logic [CFG_IW-1:0]          cfg_index,
	input  logic [CFG_DW-1:0]          cfg_data,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  logic                       converter_ready,
	input  logic signed [23:0]         raw_sample,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  logic signed [23:0]         raw_echo,
	input  logic signed [WEIGHT_W-1:0] median_weight,
	input  logic signed [WEIGHT_W-1:0] filtered_weight,
	input  logic [VAR_W-1:0]           window_variance,
	input  logic                       signal_good,
	input  logic                       stable,
	input  logic                       sample_replaced,
	output int                         fail_count,
	output int                         pending
);

	typedef struct packed {
		logic signed [23:0]         raw;
		logic signed [WEIGHT_W-1:0] median;
		logic signed [WEIGHT_W-1:0] filtered;
		logic [VAR_W-1:0]           variance;
		logic                       ok;
		logic                       stab;
		logic                       rejected;
	} weight_result_t;

	localparam logic [VAR_W-1:0] VAR_MAX = '1;

	// Calibration and thresholds as the block should hold them.
	longint offset_q, gain_q, band_q, spike_q, outlier_q;
	logic [VAR_W-1:0] fault_q, stable_q;

	// Filter state.
	logic signed [31:0] last_w;
	logic signed [31:0] med_ring [MEDIAN_DEPTH];
	int med_pos;
	bit med_full;
	logic signed [31:0] avg_ring [AVERAGE_DEPTH];
	int avg_pos;
	bit avg_full;

	weight_result_t expected_results[$];
	assign pending = expected_results.size();

	function automatic longint magnitude(longint x);
		return (x < 0) ? -x : x;
	endfunction

	// Median of the filled part of the median ring; even counts take the floor mean.
	function automatic longint ring_median();
		longint v [MEDIAN_DEPTH];
		longint key;
		int n, j;
		n = med_full ? MEDIAN_DEPTH : med_pos;
		if (n == 0)
			return last_w;
		for (int i = 0; i < n; i++)
			v[i] = med_ring[i];
		for (int i = 1; i < n; i++) begin
			key = v[i];
			j = i;
			while (j > 0 && v[j-1] > key) begin
				v[j] = v[j-1];
				j--;
			end
			v[j] = key;
		end
		if (n % 2 == 1)
			return v[n/2];
		return (v[n/2-1] + v[n/2]) >>> 1;
	endfunction

	// Advances the filter by one sample and returns the result it should give.
	function automatic weight_result_t condition_sample(logic rdy, logic signed [23:0] raw);
		weight_result_t r;
		longint w, med, sum, mean, prod;
		logic [63:0] acc, sq, d;
		logic [63:0] var64;
		int n;
		r = '0;
		if (!rdy) begin
			r.median = last_w;
			r.filtered = last_w;
			return r;
		end
		prod = (longint'(raw) - offset_q) * gain_q;
		w = prod >>> 16;
		if (w > 64'sd2147483647)
			w = 64'sd2147483647;
		else if (w < -64'sd2147483648)
			w = -64'sd2147483648;
		if (magnitude(w) < band_q)
			w = 0;
		if (magnitude(w - last_w) > spike_q) begin
			r.rejected = 1'b1;
			w = last_w;
		end
		med_ring[med_pos] = w[31:0];
		med_pos++;
		if (med_pos >= MEDIAN_DEPTH) begin
			med_pos = 0;
			med_full = 1'b1;
		end
		med = ring_median();
		if (magnitude(w - med) > outlier_q) begin
			r.rejected = 1'b1;
			w = med;
		end
		avg_ring[avg_pos] = w[31:0];
		avg_pos++;
		if (avg_pos >= AVERAGE_DEPTH) begin
			avg_pos = 0;
			avg_full = 1'b1;
		end
		n = avg_full ? AVERAGE_DEPTH : avg_pos;
		sum = 0;
		for (int i = 0; i < n; i++)
			sum += avg_ring[i];
		mean = sum / longint'(n);
		if (magnitude(mean) < band_q)
			mean = 0;
		last_w = mean[31:0];
		var64 = '0;
		if (n > 1) begin
			acc = '0;
			for (int i = 0; i < n; i++) begin
				d = magnitude(longint'(avg_ring[i]) - mean);
				sq = d * d;
				acc = (acc > ~sq) ? '1 : acc + sq;
			end
			var64 = acc / n;
			if (var64 > {16'd0, VAR_MAX})
				var64 = {16'd0, VAR_MAX};
		end
		r.raw = raw;
		r.median = med[31:0];
		r.filtered = last_w;
		r.variance = var64[VAR_W-1:0];
		r.ok = var64[VAR_W-1:0] < fault_q;
		r.stab = var64[VAR_W-1:0] <= stable_q;
		return r;
	endfunction

	// Track every transfer on the three channels.
	always @(posedge clk or negedge arst_n) begin
		weight_result_t e, a;
		if (!arst_n) begin
			offset_q <= 0;
			gain_q <= 65536;
			band_q <= 16;
			spike_q <= 16000;
			outlier_q <= 1600;
			fault_q <= 48'd25600000;
			stable_q <= 48'd256;
			last_w = 0;
			med_pos = 0;
			med_full = 0;
			avg_pos = 0;
			avg_full = 0;
			fail_count <= 0;
			expected_results.delete();
		end else begin
			// Results leave before a new sample's expectation is queued.
			if (out_valid && out_ready) begin
				a = '{raw_echo, median_weight, filtered_weight, window_variance,
					signal_good, stable, sample_replaced};
				if (expected_results.size() == 0) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10)
						$display("%0t: result transfer with nothing expected", $realtime);
				end else begin
					e = expected_results.pop_front();
					if (e !== a) begin
						fail_count <= fail_count + 1;
						if (fail_count < 10)
							$display({"%0t: mismatch exp raw=%0d med=%0d filt=%0d var=%0d ",
								"ok=%b st=%b rej=%b / got raw=%0d med=%0d filt=%0d var=%0d ",
								"ok=%b st=%b rej=%b"}, $realtime,
								e.raw, e.median, e.filtered, e.variance, e.ok, e.stab,
								e.rejected, a.raw, a.median, a.filtered, a.variance, a.ok,
								a.stab, a.rejected);
					end
				end
			end
			if (in_valid && in_ready)
				expected_results.push_back(condition_sample(converter_ready, raw_sample));
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ZERO_OFFSET: offset_q <= longint'($signed(cfg_data[23:0]));
					REG_COUNT_GAIN: gain_q <= longint'($signed(cfg_data[31:0]));
					REG_ZERO_BAND: band_q <= longint'({33'd0, cfg_data[30:0]});
					REG_SPIKE_LIMIT: spike_q <= longint'({33'd0, cfg_data[30:0]});
					REG_OUTLIER_LIMIT: outlier_q <= longint'({33'd0, cfg_data[30:0]});
					REG_FAULT_LIMIT: fault_q <= cfg_data;
					REG_STABLE_LIMIT: stable_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// Top of the weight conditioner testbench: clock, reset, sample and register stimulus,
// result back-pressure and the verdict. Depends on lcwc_pkg, the block and its checker.
module tb;
	import lcwc_pkg::*;

	// Index past the end of the register list; writes to it are ignored.
	localparam logic [CFG_IW-1:0] REG_UNUSED = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IW-1:0] cfg_index = '0;
	logic [CFG_DW-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic converter_ready = 1'b0;
	logic signed [23:0] raw_sample = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [23:0] raw_echo;
	logic signed [WEIGHT_W-1:0] median_weight, filtered_weight;
	logic [VAR_W-1:0] window_variance;
	logic signal_good, stable, sample_replaced;
	int fail_count, pending;

	int burst_left = 0;
	bit hold_off_req = 1'b0;
	longint walk;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	load_cell_weight_conditioner_unit DUT (.*);
	weight_conditioner_check u_check (.*);

	// Receiver: random stalls, stretches of full readiness and one long hold-off.
	always @(posedge clk) begin
		static int stall_left = 0;
		static int mode_left = 0;
		static bit calm = 1'b0;
		if (hold_off_req) begin
			stall_left = 600;
			hold_off_req = 1'b0;
		end
		if (mode_left == 0) begin
			calm = $urandom_range(0, 2) == 0;
			mode_left = $urandom_range(50, 800);
		end
		mode_left--;
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (calm) begin
			out_ready <= 1'b1;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 300);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Offers one sample, in bursts with random gaps between them.
	task automatic send_sample(input logic rdy, input logic signed [23:0] raw);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 400);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		converter_ready <= rdy;
		raw_sample <= raw;
		do @(posedge clk); while (!in_ready);
	endtask

	// Lets every result drain, then idles on so that the block is left clean and idle.
	// It waits for a clock edge first so that the last transfer is already counted.
	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// A scale setting with random thresholds; wide ones keep the filter moving.
	task automatic random_setup();
		write_reg(REG_ZERO_OFFSET, 48'({$urandom, $urandom}));
		write_reg(REG_COUNT_GAIN, {16'd0, 32'($urandom_range(16384, 262144))});
		write_reg(REG_ZERO_BAND, 48'({$urandom, 32'($urandom_range(0, 64))}));
		write_reg(REG_SPIKE_LIMIT, 48'({$urandom, 1'b0, 31'($urandom_range(200, 200000))}));
		write_reg(REG_OUTLIER_LIMIT, 48'({$urandom, 1'b0, 31'($urandom_range(20, 20000))}));
		write_reg(REG_FAULT_LIMIT, {16'd0, 32'($urandom_range(1000, 32'h7fffffff))});
		write_reg(REG_STABLE_LIMIT, {32'd0, 16'($urandom)});
		write_reg(REG_UNUSED, 48'({$urandom, $urandom}));
	endtask

	// Well-formed weighing: a drifting load with noise, rare spikes and dropouts.
	task automatic weigh_run(input int count);
		longint raw;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 19))
				0: send_sample(1'b0, 24'($urandom));
				1: send_sample(1'b1, 24'($urandom));
				2: begin
					walk = $signed(24'($urandom_range(0, 24'hffffff)));
					send_sample(1'b1, walk[23:0]);
				end
				default: begin
					walk += $signed(32'($urandom_range(0, 400))) - 200;
					raw = walk + $signed(32'($urandom_range(0, 60))) - 30;
					if (raw > 8388607) raw = 8388607;
					if (raw < -8388608) raw = -8388608;
					send_sample(1'b1, raw[23:0]);
				end
			endcase
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at reset settings: zero, extremes, dropout, small and big steps.
		send_sample(1'b0, 24'sd0);
		send_sample(1'b1, 24'sd0);
		send_sample(1'b1, 24'sd5);
		send_sample(1'b1, 24'sd1000);
		send_sample(1'b1, 24'sd2000);
		send_sample(1'b1, 24'sd20000);
		send_sample(1'b1, 24'sd3000);
		send_sample(1'b1, -24'sd8388608);
		send_sample(1'b1, 24'sd8388607);
		send_sample(1'b0, -24'sd1);
		drain();

		// Saturating gain and offset extremes, spike, outlier and fault limits wide open.
		write_reg(REG_ZERO_OFFSET, 48'hff_ff80_0000);
		write_reg(REG_COUNT_GAIN, 48'h0000_7fff_ffff);
		write_reg(REG_ZERO_BAND, 48'd0);
		write_reg(REG_SPIKE_LIMIT, 48'h0000_7fff_ffff);
		write_reg(REG_OUTLIER_LIMIT, 48'h0000_7fff_ffff);
		write_reg(REG_FAULT_LIMIT, '1);
		write_reg(REG_STABLE_LIMIT, '0);
		send_sample(1'b1, 24'sd8388607);
		send_sample(1'b1, -24'sd8388608);
		send_sample(1'b1, 24'sd0);
		drain();
		write_reg(REG_ZERO_OFFSET, 48'h00_007f_ffff);
		write_reg(REG_COUNT_GAIN, 48'h0000_8000_0000);
		send_sample(1'b1, -24'sd8388608);
		send_sample(1'b1, 24'sd8388607);
		send_sample(1'b1, 24'sd1);
		drain();

		// Tight limits: spike and outlier rules both bite, zero band maximal.
		write_reg(REG_ZERO_OFFSET, '0);
		write_reg(REG_COUNT_GAIN, 48'd65536);
		write_reg(REG_SPIKE_LIMIT, '0);
		write_reg(REG_OUTLIER_LIMIT, '0);
		write_reg(REG_FAULT_LIMIT, '0);
		write_reg(REG_STABLE_LIMIT, '1);
		send_sample(1'b1, 24'sd100);
		send_sample(1'b1, -24'sd100);
		drain();
		write_reg(REG_ZERO_BAND, 48'hffff_7fff_ffff);
		send_sample(1'b1, 24'sd8388607);
		send_sample(1'b0, 24'sd0);
		drain();

		// Random part: several settings, one long result hold-off, one full pause.
		walk = 0;
		for (int phase = 0; phase < 5; phase++) begin
			random_setup();
			if (phase == 2)
				hold_off_req = 1'b1;
			weigh_run(120);
			if (phase == 3) begin
				in_valid <= 1'b0;
				burst_left = 0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
			weigh_run(50);
			drain();
		end

		repeat (300) @(posedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#6000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
